[src/rse_pkg.sv]
// shared types and constants for the bitmap row span extractor
// no dependencies; imported by the interfaces and every module

package rse_pkg;

	localparam int CFG_W      = 13;       // width of the size registers
	localparam int FIELD_W    = 12;       // width of row and column fields on output
	localparam int LANES      = 8;        // pixels per byte, one lane each
	localparam int CALC_W     = CFG_W + 1; // column arithmetic, holds column plus a byte
	localparam int NUM_SLOTS  = LANES + 1; // one close per lane plus the row-end close
	localparam int FIFO_DEPTH = 4;
	localparam int CFG_IDX_W  = 2;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = CFG_W'(4096);
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = CFG_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_MSB_FIRST    = 2'd2
	} cfg_reg_t;

	// run state handed from lane to lane
	typedef struct packed {
		logic               run;
		logic [FIELD_W-1:0] start;
	} run_t;

	// what one lane found
	typedef struct packed {
		logic               close;
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] final_col;
	} lane_res_t;

	// all spans caused by one byte
	typedef struct packed {
		logic [NUM_SLOTS-1:0]              mask;
		logic [NUM_SLOTS-1:0][FIELD_W-1:0] first;
		logic [NUM_SLOTS-1:0][FIELD_W-1:0] final_col;
		logic [FIELD_W-1:0]                row;
	} group_t;

	typedef struct packed {
		logic [FIELD_W-1:0] span_row;
		logic [FIELD_W-1:0] span_first;
		logic [FIELD_W-1:0] span_final;
		logic               last_span;
	} span_t;

endpackage

[src/rse_if.sv]
// valid/ready channels for pixel bytes and spans
// depends on rse_pkg

interface rse_pixel_if import rse_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink (input valid, input pixel_byte, output ready);
endinterface

interface rse_span_if import rse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] span_row;
	logic [FIELD_W-1:0] span_first;
	logic [FIELD_W-1:0] span_final;
	logic               last_span;

	modport source (output valid, output span_row, output span_first, output span_final,
		output last_span, input ready);
	modport sink (input valid, input span_row, input span_first, input span_final,
		input last_span, output ready);
endinterface

[src/rse_lane.sv]
// one pixel lane: detects run open and close at a single column
// depends on rse_pkg

module rse_lane import rse_pkg::*; (
	input  logic              pix,
	input  logic              active,
	input  logic [CALC_W-1:0] col,
	input  run_t              chain_in,
	output run_t              chain_out,
	output lane_res_t         res
);

	logic              opens;
	logic [CALC_W-1:0] col_m1;

	assign opens  = active & pix & ~chain_in.run;
	assign col_m1 = col - CALC_W'(1);

	always_comb begin
		chain_out.run   = active ? pix : chain_in.run;
		chain_out.start = opens ? col[FIELD_W-1:0] : chain_in.start;
		res.close       = active & ~pix & chain_in.run;
		res.first       = chain_in.start;
		res.final_col   = col_m1[FIELD_W-1:0];
	end

endmodule

[src/rse_merge.sv]
// span group register: holds the spans of one byte and hands them out one a cycle while the queue is not full
// depends on rse_pkg

module rse_merge import rse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load,
	input  group_t group_in,
	input  logic   fifo_full,
	output logic   can_load,
	output logic   push,
	output span_t  span
);

	logic [NUM_SLOTS-1:0]              mask_s1;
	logic [NUM_SLOTS-1:0][FIELD_W-1:0] first_s1;
	logic [NUM_SLOTS-1:0][FIELD_W-1:0] final_s1;
	logic [FIELD_W-1:0]                row_s1;

	logic [NUM_SLOTS-1:0] pick_oh;
	logic [NUM_SLOTS-1:0] remaining;

	// lowest pending slot first, which is column order
	assign pick_oh   = mask_s1 & (~mask_s1 + NUM_SLOTS'(1));
	assign remaining = mask_s1 & ~pick_oh;
	assign push      = (mask_s1 != '0) & ~fifo_full;
	assign can_load  = (mask_s1 == '0) | (push & (remaining == '0));

	always_comb begin
		span.span_row   = row_s1;
		span.span_first = '0;
		span.span_final = '0;
		span.last_span  = (remaining == '0);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			span.span_first = span.span_first | (first_s1[i] & {FIELD_W{pick_oh[i]}});
			span.span_final = span.span_final | (final_s1[i] & {FIELD_W{pick_oh[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (load) begin
			mask_s1 <= group_in.mask;
		end else if (push) begin
			mask_s1 <= remaining;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_s1 <= group_in.first;
			final_s1 <= group_in.final_col;
			row_s1   <= group_in.row;
		end
	end

endmodule

[src/rse_span_fifo.sv]
// short span queue in front of the output channel
// depends on rse_pkg and rse_if

module rse_span_fifo import rse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  span_t       span,
	output logic        full,
	rse_span_if.source  span_out
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	span_t              mem [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;
	span_t              head;

	assign full = (count_q == CNT_W'(FIFO_DEPTH));
	assign pop  = span_out.valid & span_out.ready;
	assign head = mem[rd_ptr_q];

	assign span_out.valid      = (count_q != '0);
	assign span_out.span_row   = head.span_row;
	assign span_out.span_first = head.span_first;
	assign span_out.span_final = head.span_final;
	assign span_out.last_span  = head.last_span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= span;
		end
	end

endmodule

[src/bitmap_row_span_extractor_core.sv]
// bitmap row span extractor: eight pixel lanes per byte, span group register, span queue
// spans of a byte pass through the span group register, then the span queue, to span_out
// flow: one byte per cycle while the group register can load; its spans leave one per
// cycle while the queue is not full, stalling pixel_in until the last one is queued
// reset: asynchronous, clears run, column and row state and the queue; registers take
// image_width 4096, image_height 4096, msb_first 0

module bitmap_row_span_extractor_core import rse_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	rse_pixel_if.sink            pixel_in,
	rse_span_if.source           span_out
);

	logic [CFG_W-1:0]   image_width_q;
	logic [CFG_W-1:0]   image_height_q;
	logic               msb_first_q;

	logic               run_open_q;
	logic [FIELD_W-1:0] run_start_q;
	logic [CFG_W-1:0]   column_q;
	logic [CFG_W-1:0]   row_q;

	logic [CFG_W-1:0]   eff_w;
	logic [CFG_W-1:0]   eff_h;
	logic [LANES-1:0]   pix;
	logic [LANES-1:0]   active;
	logic [CALC_W-1:0]  col [LANES];
	run_t               chain [LANES+1];
	lane_res_t          res [LANES];

	logic               row_end;
	logic               end_close;
	logic [CALC_W-1:0]  end_base;
	logic [CALC_W-1:0]  end_col;
	logic [CALC_W-1:0]  row_inc;
	group_t             group;
	logic               accept;
	logic               load;
	logic               can_load;
	logic               fifo_full;
	logic               push;
	span_t              span;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			msb_first_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_MSB_FIRST:    msb_first_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			eff_w = CFG_W'(1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			eff_w = CFG_W'(MAX_WIDTH);
		end else begin
			eff_w = image_width_q;
		end
		if (image_height_q == '0) begin
			eff_h = CFG_W'(1);
		end else if (32'(image_height_q) > MAX_HEIGHT) begin
			eff_h = CFG_W'(MAX_HEIGHT);
		end else begin
			eff_h = image_height_q;
		end
	end

	// lanes
	assign chain[0].run   = run_open_q;
	assign chain[0].start = run_start_q;

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		assign pix[b]    = msb_first_q ? pixel_in.pixel_byte[LANES-1-b] : pixel_in.pixel_byte[b];
		assign col[b]    = CALC_W'(column_q) + CALC_W'(b);
		assign active[b] = col[b] < CALC_W'(eff_w);

		rse_lane u_lane (
			.pix       (pix[b]),
			.active    (active[b]),
			.col       (col[b]),
			.chain_in  (chain[b]),
			.chain_out (chain[b+1]),
			.res       (res[b])
		);
	end

	// row end closes whatever is still open at the last pixel seen
	assign row_end   = (CALC_W'(column_q) + CALC_W'(LANES)) >= CALC_W'(eff_w);
	assign end_close = row_end & chain[LANES].run;
	assign end_base  = (column_q >= eff_w) ? CALC_W'(column_q) : CALC_W'(eff_w);
	assign end_col   = end_base - CALC_W'(1);
	assign row_inc   = CALC_W'(row_q) + CALC_W'(1);

	always_comb begin
		group.row = row_q[FIELD_W-1:0];
		for (int i = 0; i < LANES; i++) begin
			group.mask[i]      = res[i].close;
			group.first[i]     = res[i].first;
			group.final_col[i] = res[i].final_col;
		end
		group.mask[LANES]      = end_close;
		group.first[LANES]     = chain[LANES].start;
		group.final_col[LANES] = end_col[FIELD_W-1:0];
	end

	assign pixel_in.ready = can_load;
	assign accept         = pixel_in.valid & can_load;
	assign load           = accept & (group.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q  <= 1'b0;
			run_start_q <= '0;
			column_q    <= '0;
			row_q       <= '0;
		end else if (accept) begin
			run_start_q <= chain[LANES].start;
			if (row_end) begin
				run_open_q <= 1'b0;
				column_q   <= '0;
				row_q      <= (row_inc >= CALC_W'(eff_h)) ? '0 : row_inc[CFG_W-1:0];
			end else begin
				run_open_q <= chain[LANES].run;
				column_q   <= column_q + CFG_W'(LANES);
			end
		end
	end

	rse_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.group_in  (group),
		.fifo_full (fifo_full),
		.can_load  (can_load),
		.push      (push),
		.span      (span)
	);

	rse_span_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.span     (span),
		.full     (fifo_full),
		.span_out (span_out)
	);

endmodule

[src/rse_checker.sv]
// port-level checks for bitmap_row_span_extractor_core, attached by bind
// depends on rse_pkg

module rse_checker import rse_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FIELD_W-1:0] out_row,
	input logic [FIELD_W-1:0] out_first,
	input logic [FIELD_W-1:0] out_final,
	input logic               out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("span beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_row) && $stable(out_first)
			&& $stable(out_final) && $stable(out_last))
		else $error("span payload changed while stalled");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("span queue not empty after reset");

	// queue empty now and at the previous sample, no byte just taken: the group register is free
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(out_valid) && !$past(in_valid && in_ready) |-> in_ready)
		else $error("pixel input stalled with nothing pending");

endmodule

bind bitmap_row_span_extractor_core rse_checker u_rse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_in.valid),
	.in_ready  (pixel_in.ready),
	.out_valid (span_out.valid),
	.out_ready (span_out.ready),
	.out_row   (span_out.span_row),
	.out_first (span_out.span_first),
	.out_final (span_out.span_final),
	.out_last  (span_out.last_span)
);
